// File: src/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ART_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ART_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ART_ASSERT(lbl, clk, rst, prop)
`define ART_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// File: src/art_pkg.sv
// Types and constants of the ack retransmission tracker.
// No dependencies; imported by every tracker module.
package art_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int RESULT_CAP = 16;
   localparam int NCNT_W     = $clog2(RESULT_CAP + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETX    = 1'b1;

   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_DATA = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   localparam logic [2:0] KIND_TRANSMIT = 3'd0;
   localparam logic [2:0] KIND_ACK      = 3'd1;
   localparam logic [2:0] KIND_DELIVER  = 3'd2;
   localparam logic [2:0] KIND_BROKEN   = 3'd3;
   localparam logic [2:0] KIND_FULL     = 3'd4;

   localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
   localparam logic [7:0]  MAX_RETX_RESET = 8'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] seq_nr;
      logic [15:0] source_addr;
      logic [15:0] sender_addr;
      logic [15:0] recipient_addr;
      logic [15:0] packet_handle;
      logic        is_ant;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] out_handle;
      logic [15:0] out_seq;
      logic [15:0] out_source;
      logic [15:0] out_dest;
      logic [7:0]  retry_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] seq;
      logic [15:0] source;
      logic [15:0] recipient;
      logic [15:0] handle;
      logic [7:0]  retries;
      logic [15:0] countdown;
   } entry_type;

   typedef struct packed {
      logic emit;
      logic flush;
   } rsq_ctl_type;

   typedef struct packed {
      logic emit_ready;
      logic pend_valid;
   } rsq_stat_type;

endpackage

// File: src/art_cell.sv
// One table entry of the tracker ring; takes its neighbor's entry on shift.
// Depends on art_pkg.
module art_cell import art_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type nxt_entry,
   output entry_type entry
);

   logic      valid_ff;
   entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= nxt_entry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= nxt_entry;
      end
   end

   always_comb begin
      entry       = data_ff;
      entry.valid = valid_ff;
   end

endmodule

// File: src/art_resq.sv
// Result queue: one pending slot and the output register.
// A pending result goes out with last set when the request is flushed.
// Depends on art_pkg.
module art_resq import art_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rsq_ctl_type  ctl,
   input  rsp_type      emit_data,
   output rsq_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic    pend_vld_ff, pend_vld_in;
   rsp_type pend_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;
   logic    out_free, ready, move;

   assign out_free = !out_vld_ff || rsp_ready;
   assign ready    = !pend_vld_ff || out_free;
   assign move     = pend_vld_ff && out_free && (ctl.emit || ctl.flush);

   always_comb begin
      pend_vld_in = pend_vld_ff;
      if (ctl.emit && ready) begin
         pend_vld_in = 1'b1;
      end else if (ctl.flush && ready) begin
         pend_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      out_in      = pend_ff;
      out_in.last = ctl.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit && ready) begin
         pend_ff <= emit_data;
      end
      if (move) begin
         out_ff <= out_in;
      end
   end

   assign stat.emit_ready = ready;
   assign stat.pend_valid = pend_vld_ff;
   assign rsp_valid       = out_vld_ff;
   assign rsp_data        = out_ff;

endmodule

// File: src/ack_retransmission_tracker_core.sv
// Ack retransmission tracker top: sequencer, head logic and the entry ring.
// Depends on art_pkg, art_cell, art_resq and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// Send, ack and tick requests rotate the entry ring one full lap, one entry per
// cycle past the head logic, then pass through the flush state; a send that
// finds the table full first emits a full result there.
// Data packets emit an ack unless is_ant is set, then a deliver, then flush.
// A result the output cannot take holds the ring in place.
// Reset clears all valid bits and the control state; timeout 1000, retries 3.
`include "assert_macros.svh"

module ack_retransmission_tracker_core import art_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DATA  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              found_ff, found_in;
   logic [NCNT_W-1:0] n_ff, n_in;
   logic [15:0]       timeout_ff, timeout_in;
   logic [7:0]        max_retx_ff, max_retx_in;

   entry_type    cell_q [TABLE_DEPTH];
   entry_type    head_q, head_new;
   logic         shift, need_emit, found_set;
   logic [15:0]  load_val;
   rsp_type      head_rsp, emit_data;
   rsq_ctl_type  ctl;
   rsq_stat_type rstat;

   // ---------------- configuration ----------------
   always_comb begin
      timeout_in  = timeout_ff;
      max_retx_in = max_retx_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT: timeout_in  = csr_wdata;
            CSR_MAX_RETX:    max_retx_in = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         max_retx_ff <= MAX_RETX_RESET;
      end else begin
         timeout_ff  <= timeout_in;
         max_retx_ff <= max_retx_in;
      end
   end

   assign load_val = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;

   // ---------------- entry ring ----------------
   assign head_q = cell_q[0];

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      if (k == TABLE_DEPTH - 1) begin : g_tail
         art_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift),
            .nxt_entry (head_new),
            .entry     (cell_q[k])
         );
      end else begin : g_body
         art_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift),
            .nxt_entry (cell_q[k+1]),
            .entry     (cell_q[k])
         );
      end
   end

   // ---------------- head logic ----------------
   always_comb begin
      head_new  = head_q;
      need_emit = 1'b0;
      found_set = 1'b0;
      head_rsp  = '0;
      head_rsp.kind        = KIND_TRANSMIT;
      head_rsp.out_handle  = head_q.handle;
      head_rsp.out_seq     = head_q.seq;
      head_rsp.out_source  = head_q.source;
      head_rsp.out_dest    = head_q.recipient;
      head_rsp.retry_count = head_q.retries;
      unique case (req_ff.mode)
         MODE_SEND: begin
            // first free slot in index order takes the entry
            if (!found_ff && !head_q.valid) begin
               head_new.valid     = 1'b1;
               head_new.seq       = req_ff.seq_nr;
               head_new.source    = req_ff.source_addr;
               head_new.recipient = req_ff.recipient_addr;
               head_new.handle    = req_ff.packet_handle;
               head_new.retries   = 8'd0;
               head_new.countdown = load_val;
               need_emit = 1'b1;
               found_set = 1'b1;
               head_rsp.out_handle  = req_ff.packet_handle;
               head_rsp.out_seq     = req_ff.seq_nr;
               head_rsp.out_source  = req_ff.source_addr;
               head_rsp.out_dest    = req_ff.recipient_addr;
               head_rsp.retry_count = 8'd0;
            end
         end
         MODE_ACK: begin
            if (!found_ff && head_q.valid && head_q.seq == req_ff.seq_nr &&
                head_q.source == req_ff.source_addr) begin
               head_new.valid = 1'b0;
               found_set      = 1'b1;
            end
         end
         MODE_DATA: begin
         end
         MODE_TICK: begin
            if (head_q.valid) begin
               if (head_q.countdown > 16'd1) begin
                  head_new.countdown = head_q.countdown - 16'd1;
               end else if (n_ff >= NCNT_W'(RESULT_CAP)) begin
                  // over the per-tick result limit: expire on the next tick
                  head_new.countdown = 16'd0;
               end else if (head_q.retries < max_retx_ff) begin
                  head_new.retries     = head_q.retries + 8'd1;
                  head_new.countdown   = load_val;
                  need_emit            = 1'b1;
                  head_rsp.retry_count = head_q.retries + 8'd1;
               end else begin
                  head_new.valid = 1'b0;
                  need_emit      = 1'b1;
                  head_rsp.kind  = KIND_BROKEN;
               end
            end
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      step_in   = step_ff;
      found_in  = found_ff;
      n_in      = n_ff;
      shift     = 1'b0;
      ctl       = '0;
      emit_data = head_rsp;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               step_in  = '0;
               found_in = 1'b0;
               n_in     = '0;
               state_in = (req_data.mode == MODE_DATA) ? ST_DATA : ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.emit = need_emit;
            shift    = !need_emit || rstat.emit_ready;
            if (shift) begin
               if (found_set) begin
                  found_in = 1'b1;
               end
               if (need_emit) begin
                  n_in = NCNT_W'(n_ff + 1'b1);
               end
               step_in = STEP_W'(step_ff + 1'b1);
               if (step_ff == LAST_STEP) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_DATA: begin
            ctl.emit              = 1'b1;
            emit_data             = '0;
            emit_data.out_handle  = req_ff.packet_handle;
            emit_data.out_seq     = req_ff.seq_nr;
            emit_data.out_source  = req_ff.source_addr;
            if (!req_ff.is_ant && !found_ff) begin
               emit_data.kind     = KIND_ACK;
               emit_data.out_dest = req_ff.sender_addr;
               if (rstat.emit_ready) begin
                  found_in = 1'b1;
               end
            end else begin
               emit_data.kind = KIND_DELIVER;
               if (rstat.emit_ready) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (req_ff.mode == MODE_SEND && !found_ff) begin
               ctl.emit              = 1'b1;
               emit_data             = '0;
               emit_data.kind        = KIND_FULL;
               emit_data.out_handle  = req_ff.packet_handle;
               emit_data.out_seq     = req_ff.seq_nr;
               emit_data.out_source  = req_ff.source_addr;
               emit_data.out_dest    = req_ff.recipient_addr;
               if (rstat.emit_ready) begin
                  found_in = 1'b1;
               end
            end else begin
               ctl.flush = 1'b1;
               if (rstat.emit_ready) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         found_ff <= 1'b0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         found_ff <= found_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= '0;
      end else begin
         req_ff <= req_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // ---------------- result queue ----------------
   art_resq u_resq (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .emit_data (emit_data),
      .stat      (rstat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------- checks ----------------
   `ART_ASSERT(a_idle_drained, clock, reset, (state_ff == ST_IDLE) |-> !rstat.pend_valid)
   `ART_ASSERT_NEVER(a_ack_silent, clock, reset, state_ff == ST_SCAN && req_ff.mode == MODE_ACK && ctl.emit)
   `ART_ASSERT(a_cap, clock, reset, n_ff <= NCNT_W'(RESULT_CAP))

endmodule
